FILE: sv/rdc_pkg.sv
package rdc_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int RESULT_CAP = 31;
  localparam int DIGIT_CAP  = (MAX_DIGITS < RESULT_CAP) ? MAX_DIGITS : RESULT_CAP;

  localparam int VALUE_W = 31;
  localparam int RADIX_W = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);

  // long division: work word shifted CHUNK bits a cycle, quotient bits enter at the bottom
  localparam int WORK_W = 32;
  localparam int CHUNK  = 8;
  localparam int STEPS  = WORK_W / CHUNK;
  localparam int STEP_W = $clog2(STEPS);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55);
  localparam logic [DIGIT_W-1:0] DEC_LIMIT = DIGIT_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_POP
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic push;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic             stop;
    logic             last;
    logic [CNT_W-1:0] count;
  } sts_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    return (d < DEC_LIMIT) ? (CHAR_ZERO + dx) : (CHAR_ALPHA + dx);
  endfunction

endpackage

FILE: sv/rdc_ifs.sv
interface rdc_num_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::DIGIT_W-1:0] digit;
  logic [rdc_pkg::CHAR_W-1:0]  digit_char;
  logic                        last_digit;

  modport source (output valid, output digit, output digit_char, output last_digit,
                  input ready);
  modport sink   (input valid, input digit, input digit_char, input last_digit,
                  output ready);
endinterface

interface rdc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

FILE: sv/rdc_ctrl.sv
module rdc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rdc_pkg::sts_t         sts,
  output rdc_pkg::cmd_t         cmd
);

  rdc_pkg::state_t             state, state_next;
  logic [rdc_pkg::STEP_W-1:0]  step, step_next;
  logic                        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdc_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    unique case (state)
      rdc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        cmd.step  = 1'b1;
        step_next = step + 1'b1;
        if (step == rdc_pkg::STEP_W'(rdc_pkg::STEPS - 1)) begin
          cmd.push = 1'b1;
          if (sts.stop) begin
            state_next = rdc_pkg::ST_POP;
          end
        end
      end
      rdc_pkg::ST_POP: begin
        if (!out_valid || out_ready) begin
          cmd.pop        = 1'b1;
          out_valid_next = 1'b1;
          if (sts.last) begin
            state_next = rdc_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = rdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/rdc_datapath.sv
module rdc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  rdc_cfg_if.sink                     cfg,
  input  logic [rdc_pkg::VALUE_W-1:0] value,
  input  rdc_pkg::cmd_t               cmd,
  output rdc_pkg::sts_t               sts,
  output logic [rdc_pkg::DIGIT_W-1:0] digit,
  output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
  output logic                        last_digit
);

  logic [rdc_pkg::RADIX_W-1:0] radix;
  logic [rdc_pkg::RADIX_W-1:0] radix_next;
  logic [rdc_pkg::WORK_W-1:0]  work, work_next;
  logic [rdc_pkg::DIGIT_W-1:0] rem, rem_next;
  logic [rdc_pkg::CNT_W-1:0]   count;
  logic [rdc_pkg::DIGIT_W-1:0] store [rdc_pkg::MAX_DIGITS];
  logic [rdc_pkg::ADDR_W-1:0]  push_addr, pop_addr;
  logic [rdc_pkg::CNT_W-1:0]   count_dec;

  assign cfg.ready = 1'b1;

  always_comb begin
    radix_next = cfg.radix;
    if (cfg.radix < rdc_pkg::RADIX_MIN) begin
      radix_next = rdc_pkg::RADIX_MIN;
    end else if (cfg.radix > rdc_pkg::RADIX_MAX) begin
      radix_next = rdc_pkg::RADIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg.valid) begin
      radix <= radix_next;
    end
  end

  // CHUNK restoring-division steps on a remainder below the radix
  always_comb begin
    logic [rdc_pkg::RADIX_W-1:0] t;
    logic [rdc_pkg::DIGIT_W-1:0] r;
    logic [rdc_pkg::CHUNK-1:0]   q;
    r = rem;
    q = '0;
    for (int i = 0; i < rdc_pkg::CHUNK; i++) begin
      t = {r, work[rdc_pkg::WORK_W-1-i]};
      if (t >= radix) begin
        t = t - radix;
        q[rdc_pkg::CHUNK-1-i] = 1'b1;
      end
      r = t[rdc_pkg::DIGIT_W-1:0];
    end
    rem_next  = r;
    work_next = {work[rdc_pkg::WORK_W-rdc_pkg::CHUNK-1:0], q};
  end

  assign count_dec = count - 1'b1;
  assign push_addr = count[rdc_pkg::ADDR_W-1:0];
  assign pop_addr  = count_dec[rdc_pkg::ADDR_W-1:0];

  assign sts.stop  = (work_next == '0) ||
                     (count == rdc_pkg::CNT_W'(rdc_pkg::DIGIT_CAP - 1));
  assign sts.last  = (count == rdc_pkg::CNT_W'(1));
  assign sts.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= rdc_pkg::WORK_W'(value);
      rem  <= '0;
    end else if (cmd.step) begin
      work <= work_next;
      rem  <= cmd.push ? '0 : rem_next;
    end
    if (cmd.push) begin
      store[push_addr] <= rem_next;
    end
    if (cmd.pop) begin
      digit      <= store[pop_addr];
      digit_char <= rdc_pkg::hex_char(store[pop_addr]);
      last_digit <= sts.last;
    end
  end

endmodule

FILE: sv/radix_digit_converter.sv
// radix_digit_converter
// Converts each number item into its digits in the configured radix (2 to 16;
// lower codes act as 2, higher as 16). One digit item per digit, most
// significant first, with its uppercase hex character; last_digit marks the
// least significant digit. Zero gives the single digit 0. At most 31 digits.
// cfg: radix write, always ready; write only while the block is idle.
// number: taken only when no conversion is in progress.
// Operation for an item of D digits: the divider produces all D digits by
// long division (8 quotient bits a cycle over a 32-bit word) before the
// first digit is presented; the digits then leave one per cycle while the
// sink is ready.
// digits: registered output; a stalled sink holds the current digit and
// pauses the digit stack. number.ready returns once the last digit is loaded
// into the output register, even if it has not been taken yet.
// Reset (rst, synchronous): radix returns to 10, any conversion is dropped.
module radix_digit_converter (
  input logic          clk,
  input logic          rst,
  rdc_cfg_if.sink      cfg,
  rdc_num_if.sink      number,
  rdc_digit_if.source  digits
);

  rdc_pkg::cmd_t cmd;
  rdc_pkg::sts_t sts;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (digits.valid),
    .out_ready (digits.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rdc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .value      (number.value),
    .cmd        (cmd),
    .sts        (sts),
    .digit      (digits.digit),
    .digit_char (digits.digit_char),
    .last_digit (digits.last_digit)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    number.valid && number.ready |=> !number.ready)
    else $error("number accepted while a conversion is starting");

  a_char_matches: assert property (@(posedge clk) disable iff (rst)
    digits.valid |-> digits.digit_char == rdc_pkg::hex_char(digits.digit))
    else $error("digit character does not match digit");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    sts.count <= rdc_pkg::CNT_W'(rdc_pkg::DIGIT_CAP))
    else $error("digit stack overflow");

  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop) && !(cmd.pop && sts.count == '0))
    else $error("stack push/pop conflict or pop of empty stack");
`endif

endmodule

FILE: bench/tb_radix_digit_converter.sv
`timescale 1ns / 100ps

module tb_radix_digit_converter;

  typedef struct packed {
    logic [rdc_pkg::DIGIT_W-1:0] digit;
    logic [rdc_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;
  } digit_rec_t;

  typedef struct {
    logic [rdc_pkg::RADIX_W-1:0] radix;
    logic [rdc_pkg::VALUE_W-1:0] value;
    string                       text;
  } dir_row_t;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 300;

  logic clk;
  logic rst;

  rdc_cfg_if   cfg_bus ();
  rdc_num_if   num_bus ();
  rdc_digit_if dig_bus ();

  radix_digit_converter dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .number (num_bus),
    .digits (dig_bus)
  );

  digit_rec_t                  pending_digits[$];
  logic [rdc_pkg::RADIX_W-1:0] radix_now;
  int                          mismatches;
  bit                          no_gaps;
  bit                          hold_request;

  // empty text: checked against the digit predictor
  dir_row_t dir_rows [20] = '{
    '{5'd10, 31'd0,          "0"},
    '{5'd10, 31'h7FFFFFFF,   "2147483647"},
    '{5'd10, 31'd9,          "9"},
    '{5'd10, 31'd10,         "10"},
    '{5'd2,  31'h7FFFFFFF,   "1111111111111111111111111111111"},
    '{5'd2,  31'd0,          "0"},
    '{5'd2,  31'd1,          "1"},
    '{5'd2,  31'h40000000,   "1000000000000000000000000000000"},
    '{5'd16, 31'h7FFFFFFF,   "7FFFFFFF"},
    '{5'd16, 31'h0ABCDEF0,   "ABCDEF0"},
    '{5'd16, 31'd15,         "F"},
    '{5'd0,  31'd5,          "101"},
    '{5'd1,  31'd6,          "110"},
    '{5'd17, 31'd255,        "FF"},
    '{5'd31, 31'h12345678,   "12345678"},
    '{5'd3,  31'h7FFFFFFF,   ""},
    '{5'd7,  31'd123456789,  ""},
    '{5'd11, 31'h55555555,   ""},
    '{5'd15, 31'h2AAAAAAA,   ""},
    '{5'd9,  31'd80,         ""}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // repeated division, digits queued most significant first
  function automatic void convert_to_digits(input logic [rdc_pkg::VALUE_W-1:0] v,
                                            input logic [rdc_pkg::RADIX_W-1:0] code);
    logic [31:0]                 n;
    logic [31:0]                 base;
    logic [rdc_pkg::DIGIT_W-1:0] stack [rdc_pkg::MAX_DIGITS];
    int                          cnt;
    digit_rec_t                  rec;
    base = (code < 2) ? 32'd2 : (code > 16) ? 32'd16 : 32'(code);
    n = 32'(v);
    cnt = 0;
    do begin
      stack[cnt] = rdc_pkg::DIGIT_W'(n % base);
      cnt++;
      n = n / base;
    end while (n != 0 && cnt < rdc_pkg::DIGIT_CAP);
    for (int i = cnt - 1; i >= 0; i--) begin
      rec.digit      = stack[i];
      rec.digit_char = (stack[i] < 10) ? rdc_pkg::CHAR_W'(48 + stack[i]) :
                                         rdc_pkg::CHAR_W'(55 + stack[i]);
      rec.last_digit = (i == 0);
      pending_digits.push_back(rec);
    end
  endfunction

  function automatic void digits_from_text(input string text);
    digit_rec_t rec;
    byte        c;
    for (int i = 0; i < text.len(); i++) begin
      c = text[i];
      rec.digit      = (c >= "A") ? rdc_pkg::DIGIT_W'(c - 55) : rdc_pkg::DIGIT_W'(c - 48);
      rec.digit_char = rdc_pkg::CHAR_W'(c);
      rec.last_digit = (i == text.len() - 1);
      pending_digits.push_back(rec);
    end
  endfunction

  task automatic send_number(input logic [rdc_pkg::VALUE_W-1:0] v, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      num_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    num_bus.valid <= 1'b1;
    num_bus.value <= v;
    do @(posedge clk); while (!num_bus.ready);
    if (text.len() == 0) convert_to_digits(v, radix_now);
    else digits_from_text(text);
  endtask

  task automatic wait_idle();
    num_bus.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] r);
    cfg_bus.valid <= 1'b1;
    cfg_bus.radix <= r;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    radix_now = r;
  endtask

  // digit sink: random stalls, one long hold-off on request
  initial begin
    int         stall_left;
    digit_rec_t got;
    digit_rec_t want;
    stall_left = 0;
    dig_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (dig_bus.valid && dig_bus.ready) begin
        got = '{dig_bus.digit, dig_bus.digit_char, dig_bus.last_digit};
        if (pending_digits.size() == 0) begin
          $display("%0t: unexpected digit item: digit=%0d char=%0d last=%0b",
                   $time, got.digit, got.digit_char, got.last_digit);
          mismatches++;
        end else begin
          want = pending_digits.pop_front();
          if (got.digit !== want.digit || got.digit_char !== want.digit_char ||
              got.last_digit !== want.last_digit) begin
            $display("%0t: mismatch exp digit=%0d char=%0d last=%0b got digit=%0d char=%0d last=%0b",
                     $time, want.digit, want.digit_char, want.last_digit,
                     got.digit, got.digit_char, got.last_digit);
            mismatches++;
          end
        end
      end
      if (hold_request) begin
        stall_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        dig_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        dig_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [rdc_pkg::RADIX_W-1:0] phase_radix;
    logic [rdc_pkg::VALUE_W-1:0] v;
    int                          nbits;
    mismatches   = 0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    radix_now    = rdc_pkg::RADIX_RESET;
    rst          = 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.radix <= '0;
    num_bus.valid <= 1'b0;
    num_bus.value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].radix != radix_now) begin
        wait_idle();
        write_radix(dir_rows[k].radix);
      end
      send_number(dir_rows[k].value, dir_rows[k].text);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_radix = 5'd2;
        1: phase_radix = 5'd16;
        2: phase_radix = 5'd31;
        3: phase_radix = 5'd0;
        default: phase_radix = rdc_pkg::RADIX_W'($urandom_range(0, 31));
      endcase
      wait_idle();
      write_radix(phase_radix);
      no_gaps = (p == 4) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 1 && i == 10) hold_request = 1'b1;
        nbits = $urandom_range(0, rdc_pkg::VALUE_W);
        v = rdc_pkg::VALUE_W'($urandom);
        if (nbits < rdc_pkg::VALUE_W) v = v & ((rdc_pkg::VALUE_W'(1) << nbits) - 1'b1);
        send_number(v, "");
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
